>>> src/scrm_pkg.sv
// ----------------------------------------------------------------------------
// scrm_pkg
// Shared types, codes and constants of the stereo crossfade mixer.
// ----------------------------------------------------------------------------
package scrm_pkg;

  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned RUN_W     = 33;
  localparam int unsigned STEP_W    = 34;
  localparam int unsigned FRAME_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = FRAME_W;

  localparam logic [GAIN_W-1:0] UNITY = 17'h10000;
  localparam logic [GAIN_W-1:0] HALF  = 17'h08000;
  localparam logic [RUN_W-1:0]  RUN_MAX = 33'h1_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION     = 2'd0,
    CFG_CURVE        = 2'd1,
    CFG_BLOCK_FRAMES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CURVE_LINEAR = 3'd0,
    CURVE_DIP    = 3'd1,
    CURVE_CUT    = 3'd2,
    CURVE_SMOOTH = 3'd3,
    CURVE_EQPOW  = 3'd4
  } curve_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TARGET,
    ST_DIP_MUL,
    ST_DIP_ACC,
    ST_SMS_MUL1,
    ST_SMS_MUL2,
    ST_SMS_ACC,
    ST_EQP_POS,
    ST_EQP_LO,
    ST_EQP_HI,
    ST_EQP_DIFF,
    ST_EQP_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RAMP,
    ST_GAIN,
    ST_MIX_CL,
    ST_MIX_CR,
    ST_MIX_OL,
    ST_MIX_OR,
    ST_MIX_END,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  // sin(pi/2 * t), t in Q30 over [0, 1], result Q1.16
  function automatic logic [GAIN_W-1:0] quarter_sine(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] r;
    u = (t * t) >> 30;
    p = 64'd172272 - ((64'd3864 * u) >> 30);
    p = 64'd5026995 - ((p * u) >> 30);
    p = 64'd85569306 - ((p * u) >> 30);
    p = 64'd693598668 - ((p * u) >> 30);
    p = 64'd1686629713 - ((p * u) >> 30);
    r = (p * t) >> 30;
    r = (r + 64'd8192) >> 14;
    if (r > 64'(UNITY)) begin
      r = 64'(UNITY);
    end
    return r[GAIN_W-1:0];
  endfunction

endpackage

>>> src/scrm_mul.sv
// ----------------------------------------------------------------------------
// scrm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module scrm_mul import scrm_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] op_a_i,
  input  logic signed [MUL_B_W-1:0] op_b_i,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> src/scrm_div.sv
// ----------------------------------------------------------------------------
// scrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scrm_div import scrm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

>>> src/scrm_sine_rom.sv
// ----------------------------------------------------------------------------
// scrm_sine_rom
// Quarter-sine table, Q1.16 entries, registered read.
// ----------------------------------------------------------------------------
module scrm_sine_rom import scrm_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic [$clog2(DEPTH + 1)-1:0]     addr_i,
  output logic [GAIN_W-1:0]                data_o
);

  logic [GAIN_W-1:0] rom_c [DEPTH + 1];
  logic [GAIN_W-1:0] data_q;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [63:0] T = (64'(k) << 30) / DEPTH;
    assign rom_c[k] = quarter_sine(T);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_c[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> src/stereo_crossfade_ramped_mixer_unit.sv
// ----------------------------------------------------------------------------
// stereo_crossfade_ramped_mixer_unit
// Stereo crossfader with curve-shaped target gains ramped over each block.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        sink       in_valid_i / in_ready_o  carrier/other left+right, present
// out       source     out_valid_o / out_ready_i out_left, out_right, block_end
// cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// a frame inside a block passes through the ramp, gain rounding, four products
// on the one shared multiplier and the output stage
// the first frame of a block adds the target curve and two 33-bit serial
// divides for the ramp steps
// reset restores unity carrier gain and no ramp; no clearing pass is needed
// a result waiting on out_ready_i does not stop the next transaction from
// being taken; only a second finished result waits for the output register
// ----------------------------------------------------------------------------
module stereo_crossfade_ramped_mixer_unit import scrm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned MAX_FRAMES       = 4096,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] carrier_left_i,
  input  logic signed [SAMPLE_BITS-1:0] carrier_right_i,
  input  logic signed [SAMPLE_BITS-1:0] other_left_i,
  input  logic signed [SAMPLE_BITS-1:0] other_right_i,
  input  logic                         other_present_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_left_o,
  output logic signed [SAMPLE_BITS-1:0] out_right_o,
  output logic                         block_end_o
);

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned RND_W = MUL_P_W - 16;
  localparam logic signed [RND_W-1:0] SAT_HI =
    (RND_W'(1) <<< (SAMPLE_BITS - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  state_e state_q, state_d;

  logic [GAIN_W-1:0]   position_q;
  logic [2:0]          curve_q;
  logic [FRAME_W-1:0]  bframes_q;

  logic [GAIN_W-1:0]   settled_a_q, settled_b_q;
  logic [GAIN_W-1:0]   tgt_a_q, tgt_b_q;
  logic [RUN_W-1:0]    run_a_q, run_b_q;
  logic [STEP_W-1:0]   step_a_q, step_b_q;
  logic [FRAME_W-1:0]  frame_idx_q;
  logic                sel_q;
  logic [GAIN_W-1:0]   lo_q;
  logic [15:0]         frac_q;
  logic [AW-1:0]       lo_addr_q;
  logic                at_end_q;
  logic [GAIN_W-1:0]   ga_q, gb_q;
  logic signed [MUL_P_W-1:0] acc_l_q, acc_r_q;
  logic signed [SAMPLE_BITS-1:0] cl_q, cr_q, ol_q, or_q;
  logic                present_q;
  logic                last_q;
  logic                out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;
  logic                out_end_q;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [AW-1:0]       rom_addr;
  logic [GAIN_W-1:0]   rom_data;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [GAIN_W-1:0]   x_c, y_c, v_c;
  logic [FRAME_W-1:0]  frames_c;
  logic                last_c;
  logic                in_acc;
  logic                out_free;
  logic [GAIN_W-1:0]   diff_c;
  logic                neg_c;
  logic [GAIN_W-1:0]   tgt_sel, set_sel;
  logic [AW-1:0]       idx_c;
  logic [GAIN_W-1:0]   dip_r, eqp_r, sms_s;
  logic [MUL_P_W-1:0]  sum16, sum32;
  logic [STEP_W-1:0]   step_c;
  logic [GAIN_W-1:0]   eqp_d;
  logic signed [MUL_P_W-1:0] rnd_l, rnd_r;
  logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;

  function automatic logic [RUN_W-1:0] clamp_run(input logic [RUN_W-1:0] run,
                                                 input logic [STEP_W-1:0] step);
    logic signed [STEP_W:0] sum;
    sum = $signed({2'b00, run}) + $signed({step[STEP_W-1], step});
    if (sum[STEP_W]) begin
      return '0;
    end else if (sum > $signed({2'b00, RUN_MAX})) begin
      return RUN_MAX;
    end
    return sum[RUN_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [MUL_P_W-1:0] sum);
    logic signed [RND_W-1:0] v;
    v = sum[MUL_P_W-1:16];
    if (v > SAT_HI) begin
      v = SAT_HI;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  scrm_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  scrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  scrm_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shared helpers
  assign x_c = (position_q > UNITY) ? UNITY : position_q;
  assign y_c = UNITY - x_c;
  assign v_c = sel_q ? y_c : x_c;

  always_comb begin
    frames_c = bframes_q;
    if (bframes_q == '0) begin
      frames_c = FRAME_W'(1);
    end else if (32'(bframes_q) > MAX_FRAMES) begin
      frames_c = FRAME_W'(MAX_FRAMES);
    end
  end

  assign last_c   = ({1'b0, frame_idx_q} + (FRAME_W + 1)'(1)) >= {1'b0, frames_c};
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign tgt_sel = sel_q ? tgt_b_q : tgt_a_q;
  assign set_sel = sel_q ? settled_b_q : settled_a_q;
  assign neg_c   = tgt_sel < set_sel;
  assign diff_c  = neg_c ? (set_sel - tgt_sel) : (tgt_sel - set_sel);
  assign step_c  = neg_c ? (STEP_W'(0) - STEP_W'(div_rsp.quo)) : STEP_W'(div_rsp.quo);

  assign sum16 = prod + MUL_P_W'(32768);
  assign sum32 = prod + MUL_P_W'(64'h8000_0000);
  assign dip_r = sum16[16 +: GAIN_W];
  assign eqp_r = lo_q + sum16[16 +: GAIN_W];
  assign sms_s = (sum32[32 +: 18] > 18'(UNITY)) ? UNITY : sum32[32 +: GAIN_W];
  assign idx_c = prod[16 +: AW];
  assign eqp_d = (rom_data >= lo_q) ? (rom_data - lo_q) : '0;

  assign rnd_l = acc_l_q + MUL_P_W'(32768);
  assign rnd_r = acc_r_q + MUL_P_W'(32768);
  assign sat_l = saturate(rnd_l);
  assign sat_r = saturate(rnd_r);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (frame_idx_q == '0) ? ST_TARGET : ST_RAMP;
        end
      end
      ST_TARGET: begin
        if (x_c == '0 || x_c == UNITY) begin
          state_d = ST_DIV_START;
        end else begin
          case (curve_q)
            CURVE_LINEAR, CURVE_CUT: state_d = ST_DIV_START;
            CURVE_DIP:               state_d = ST_DIP_MUL;
            CURVE_SMOOTH:            state_d = ST_SMS_MUL1;
            default:                 state_d = ST_EQP_POS;
          endcase
        end
      end
      ST_DIP_MUL:  state_d = ST_DIP_ACC;
      ST_DIP_ACC:  state_d = sel_q ? ST_DIV_START : ST_DIP_MUL;
      ST_SMS_MUL1: state_d = ST_SMS_MUL2;
      ST_SMS_MUL2: state_d = ST_SMS_ACC;
      ST_SMS_ACC:  state_d = ST_DIV_START;
      ST_EQP_POS:  state_d = ST_EQP_LO;
      ST_EQP_LO:   state_d = ST_EQP_HI;
      ST_EQP_HI:   state_d = ST_EQP_DIFF;
      ST_EQP_DIFF: state_d = ST_EQP_ACC;
      ST_EQP_ACC:  state_d = sel_q ? ST_DIV_START : ST_EQP_POS;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = sel_q ? ST_RAMP : ST_DIV_START;
        end
      end
      ST_RAMP:    state_d = ST_GAIN;
      ST_GAIN:    state_d = ST_MIX_CL;
      ST_MIX_CL:  state_d = ST_MIX_CR;
      ST_MIX_CR:  state_d = ST_MIX_OL;
      ST_MIX_OL:  state_d = ST_MIX_OR;
      ST_MIX_OR:  state_d = ST_MIX_END;
      ST_MIX_END: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    rom_addr = '0;
    div_req  = '0;
    unique case (state_q)
      ST_DIP_MUL: begin
        op_a = MUL_A_W'(v_c);
        op_b = MUL_B_W'(v_c);
      end
      ST_SMS_MUL1: begin
        op_a = MUL_A_W'(x_c);
        op_b = MUL_B_W'(x_c);
      end
      ST_SMS_MUL2: begin
        op_a = prod[MUL_A_W-1:0];
        op_b = MUL_B_W'(18'd196608 - {x_c, 1'b0});
      end
      ST_EQP_POS: begin
        op_a = MUL_A_W'(v_c);
        op_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      ST_EQP_LO: begin
        rom_addr = ({1'b0, idx_c} >= (AW + 1)'(SINE_TABLE_DEPTH)) ?
                   AW'(SINE_TABLE_DEPTH) : idx_c;
      end
      ST_EQP_HI: begin
        rom_addr = at_end_q ? lo_addr_q : lo_addr_q + AW'(1);
      end
      ST_EQP_DIFF: begin
        op_a = MUL_A_W'(eqp_d);
        op_b = MUL_B_W'(frac_q);
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        div_req.num   = {diff_c[15:0] == '0 && diff_c[16], diff_c[15:0], 16'b0};
        div_req.den   = frames_c;
      end
      ST_MIX_CL: begin
        op_a = MUL_A_W'(cl_q);
        op_b = MUL_B_W'(ga_q);
      end
      ST_MIX_CR: begin
        op_a = MUL_A_W'(cr_q);
        op_b = MUL_B_W'(ga_q);
      end
      ST_MIX_OL: begin
        op_a = MUL_A_W'(ol_q);
        op_b = MUL_B_W'(gb_q);
      end
      ST_MIX_OR: begin
        op_a = MUL_A_W'(or_q);
        op_b = MUL_B_W'(gb_q);
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      position_q  <= '0;
      curve_q     <= CURVE_EQPOW;
      bframes_q   <= FRAME_W'(64);
      settled_a_q <= UNITY;
      settled_b_q <= '0;
      run_a_q     <= RUN_MAX;
      run_b_q     <= '0;
      step_a_q    <= '0;
      step_b_q    <= '0;
      frame_idx_q <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POSITION:     position_q <= cfg_data_i;
          CFG_CURVE:        curve_q    <= cfg_data_i[2:0];
          CFG_BLOCK_FRAMES: bframes_q  <= cfg_data_i[FRAME_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_DIP_ACC, ST_EQP_ACC: sel_q <= !sel_q;
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            sel_q <= !sel_q;
            if (sel_q) begin
              step_b_q    <= step_c;
              settled_a_q <= tgt_a_q;
              settled_b_q <= tgt_b_q;
            end else begin
              step_a_q <= step_c;
            end
          end
        end
        ST_RAMP: begin
          frame_idx_q <= last_c ? '0 : frame_idx_q + FRAME_W'(1);
          if (last_c) begin
            run_a_q <= {settled_a_q, 16'b0};
            run_b_q <= {settled_b_q, 16'b0};
          end else begin
            run_a_q <= clamp_run(run_a_q, step_a_q);
            run_b_q <= clamp_run(run_b_q, step_b_q);
          end
        end
        default: begin
        end
      endcase
      // ramp restarts from the old targets at a block start
      if (state_q == ST_DIV_WAIT && div_rsp.done && sel_q) begin
        run_a_q <= {settled_a_q, 16'b0};
        run_b_q <= {settled_b_q, 16'b0};
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cl_q      <= carrier_left_i;
      cr_q      <= carrier_right_i;
      ol_q      <= other_left_i;
      or_q      <= other_right_i;
      present_q <= other_present_i;
    end
    case (state_q)
      ST_TARGET: begin
        if (x_c == '0) begin
          tgt_a_q <= UNITY;
          tgt_b_q <= '0;
        end else if (x_c == UNITY) begin
          tgt_a_q <= '0;
          tgt_b_q <= UNITY;
        end else if (curve_q == CURVE_LINEAR) begin
          tgt_a_q <= y_c;
          tgt_b_q <= x_c;
        end else if (x_c < HALF) begin
          tgt_a_q <= UNITY;
          tgt_b_q <= '0;
        end else begin
          tgt_a_q <= '0;
          tgt_b_q <= UNITY;
        end
      end
      ST_DIP_ACC: begin
        if (sel_q) begin
          tgt_a_q <= dip_r;
        end else begin
          tgt_b_q <= dip_r;
        end
      end
      ST_SMS_ACC: begin
        tgt_b_q <= sms_s;
        tgt_a_q <= UNITY - sms_s;
      end
      ST_EQP_LO: begin
        at_end_q  <= {1'b0, idx_c} >= (AW + 1)'(SINE_TABLE_DEPTH);
        lo_addr_q <= rom_addr;
        frac_q    <= ({1'b0, idx_c} >= (AW + 1)'(SINE_TABLE_DEPTH)) ? '0 : prod[15:0];
      end
      ST_EQP_HI: lo_q <= rom_data;
      ST_EQP_ACC: begin
        if (sel_q) begin
          tgt_a_q <= eqp_r;
        end else begin
          tgt_b_q <= eqp_r;
        end
      end
      ST_RAMP: last_q <= last_c;
      ST_GAIN: begin
        ga_q <= GAIN_W'(({1'b0, run_a_q} + (RUN_W + 1)'(32768)) >> 16);
        gb_q <= GAIN_W'(({1'b0, run_b_q} + (RUN_W + 1)'(32768)) >> 16);
      end
      ST_MIX_CR: acc_l_q <= prod;
      ST_MIX_OL: acc_r_q <= prod;
      ST_MIX_OR: begin
        if (present_q) begin
          acc_l_q <= acc_l_q + prod;
        end
      end
      ST_MIX_END: begin
        if (present_q) begin
          acc_r_q <= acc_r_q + prod;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_l_q   <= sat_l;
          out_r_q   <= sat_r;
          out_end_q <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign block_end_o = out_end_q;

endmodule

>>> src/scrm_checker.sv
// ----------------------------------------------------------------------------
// scrm_checker
// Port-level checks of the crossfade mixer, bound to the top level.
// ----------------------------------------------------------------------------
module scrm_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_left_o,
  input logic [SAMPLE_BITS-1:0] out_right_o,
  input logic                   block_end_o
);

  // a result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_left_o) && $stable(out_right_o) && $stable(block_end_o))
    else $error("result changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  // a new result appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in work");

endmodule

bind stereo_crossfade_ramped_mixer_unit scrm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_scrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_left_o  (out_left_o),
  .out_right_o (out_right_o),
  .block_end_o (block_end_o)
);
